// ===== rtl/ipt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_pkg - indexed priority task table shared definitions
// Types, codes and defaults used by the cell chain, the controller and the top.
// ----------------------------------------------------------------------------
package ipt_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 64;
  localparam int unsigned PRIO_W          = 32;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned KEY_W           = PRIO_W + ID_W;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_EDIT   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EXEC   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_REMOVE = 2'd1,
    S_INSERT = 2'd2
  } state_e;

  // payload of one table slot
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   task_id;
    logic [ID_W-1:0]   user;
  } slot_t;

  typedef struct packed {
    logic  valid;
    slot_t data;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             rm_en;
    logic             ins_en;
    logic [KEY_W-1:0] key;
    slot_t            ins_slot;
    logic [ID_W-1:0]  match_tid;
  } cell_cmd_t;

  // table lookup results seen by the controller
  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    logic  empty;
    logic  full;
    slot_t head;
  } lookup_t;

endpackage
`default_nettype wire

// ===== rtl/ipt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_cell - one cell of the sorted task chain
// Holds one entry; shifts toward the head on removal and toward the tail on
// insertion, keeping the chain sorted by descending (priority, task id).
// ----------------------------------------------------------------------------
module ipt_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ipt_pkg::cell_cmd_t cmd_i,
  input  wire ipt_pkg::entry_t    prev_i,
  input  wire logic               prev_lt_i,
  input  wire ipt_pkg::entry_t    next_i,
  output ipt_pkg::entry_t         entry_o,
  output logic                    lt_o,
  output logic                    hit_o
);

  logic                      valid_q, valid_d;
  ipt_pkg::slot_t            data_q, data_d;
  logic [ipt_pkg::KEY_W-1:0] my_key;
  logic                      key_gt;

  // key compare against the broadcast key
  assign my_key = {data_q.prio, data_q.task_id};
  assign key_gt = my_key > cmd_i.key;
  assign lt_o   = !valid_q || (my_key < cmd_i.key);
  assign hit_o  = valid_q && (data_q.task_id == cmd_i.match_tid);

  assign entry_o.valid = valid_q;
  assign entry_o.data  = data_q;

  // next cell contents
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.rm_en && valid_q && !key_gt) begin
      valid_d = next_i.valid;
      data_d  = next_i.data;
    end else if (cmd_i.ins_en && lt_o) begin
      if (!prev_lt_i) begin
        valid_d = 1'b1;
        data_d  = cmd_i.ins_slot;
      end else begin
        valid_d = prev_i.valid;
        data_d  = prev_i.data;
      end
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
`default_nettype wire

// ===== rtl/ipt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_ctrl - request sequencer for the task table
// Decodes a request against the table lookup, steps the chain through its
// remove and insert passes and registers the response.
// ----------------------------------------------------------------------------
module ipt_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [ipt_pkg::ID_W-1:0]      user_id_i,
  input  wire logic [ipt_pkg::ID_W-1:0]      task_id_i,
  input  wire logic [ipt_pkg::PRIO_W-1:0]    priority_req_i,
  input  wire ipt_pkg::lookup_t              look_i,
  output logic                               busy,
  output ipt_pkg::cell_cmd_t                 cmd_o,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [ipt_pkg::ID_W-1:0]           top_user_o
);

  ipt_pkg::state_e           state_q, state_d;
  logic [ipt_pkg::KEY_W-1:0] rm_key_q, rm_key_d;
  ipt_pkg::slot_t            ins_q, ins_d;
  logic                      ins_pend_q, ins_pend_d;
  logic                      done_q, done_d;
  ipt_pkg::status_e          status_q, status_d;
  logic [ipt_pkg::ID_W-1:0]  top_user_q, top_user_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipt_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    rm_key_q   <= rm_key_d;
    ins_q      <= ins_d;
    ins_pend_q <= ins_pend_d;
    status_q   <= status_d;
    top_user_q <= top_user_d;
  end

  // next state and decode
  always_comb begin
    state_d    = state_q;
    rm_key_d   = rm_key_q;
    ins_d      = ins_q;
    ins_pend_d = ins_pend_q;
    done_d     = 1'b0;
    status_d   = status_q;
    top_user_d = top_user_q;
    case (state_q)
      ipt_pkg::S_IDLE: begin
        if (start) begin
          status_d   = ipt_pkg::ST_OK;
          top_user_d = '0;
          ins_d      = '{prio: priority_req_i, task_id: task_id_i, user: user_id_i};
          rm_key_d   = {look_i.hit_slot.prio, task_id_i};
          ins_pend_d = 1'b0;
          case (ipt_pkg::opcode_e'(opcode_i))
            ipt_pkg::OP_ADD: begin
              if (look_i.hit) begin
                ins_pend_d = 1'b1;
                state_d    = ipt_pkg::S_REMOVE;
              end else if (look_i.full) begin
                status_d = ipt_pkg::ST_FULL;
                done_d   = 1'b1;
              end else begin
                state_d = ipt_pkg::S_INSERT;
              end
            end
            ipt_pkg::OP_EDIT: begin
              ins_d.user = look_i.hit_slot.user;
              if (look_i.hit) begin
                ins_pend_d = 1'b1;
                state_d    = ipt_pkg::S_REMOVE;
              end else begin
                status_d = ipt_pkg::ST_NOT_FOUND;
                done_d   = 1'b1;
              end
            end
            ipt_pkg::OP_REMOVE: begin
              if (look_i.hit) begin
                state_d = ipt_pkg::S_REMOVE;
              end else begin
                status_d = ipt_pkg::ST_NOT_FOUND;
                done_d   = 1'b1;
              end
            end
            default: begin
              // execute top: pop the head cell
              rm_key_d = {look_i.head.prio, look_i.head.task_id};
              if (look_i.empty) begin
                status_d = ipt_pkg::ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                top_user_d = look_i.head.user;
                state_d    = ipt_pkg::S_REMOVE;
              end
            end
          endcase
        end
      end
      ipt_pkg::S_REMOVE: begin
        if (ins_pend_q) begin
          state_d = ipt_pkg::S_INSERT;
        end else begin
          state_d = ipt_pkg::S_IDLE;
          done_d  = 1'b1;
        end
      end
      ipt_pkg::S_INSERT: begin
        state_d = ipt_pkg::S_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = ipt_pkg::S_IDLE;
      end
    endcase
  end

  // chain command
  always_comb begin
    cmd_o.rm_en     = (state_q == ipt_pkg::S_REMOVE);
    cmd_o.ins_en    = (state_q == ipt_pkg::S_INSERT);
    cmd_o.key       = (state_q == ipt_pkg::S_REMOVE) ? rm_key_q : {ins_q.prio, ins_q.task_id};
    cmd_o.ins_slot  = ins_q;
    cmd_o.match_tid = task_id_i;
  end

  assign busy       = (state_q != ipt_pkg::S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign top_user_o = top_user_q;

endmodule
`default_nettype wire

// ===== rtl/indexed_priority_task_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_priority_task_table - task table with priority pop
// Sorted chain of cells holding (task id, user id, priority) entries.
// ----------------------------------------------------------------------------
// Usage
//   Request: drive opcode_i, user_id_i, task_id_i and priority_req_i with start
//   high; the request is taken at a rising edge where start is high and busy
//   is low. Opcodes: add, edit priority, remove, execute top.
//   Response: done_o is high for one cycle with status_o and top_user_o; the
//   receiver cannot stall, so the response must be taken in that cycle.
//   Passes: a request that changes nothing (full, empty, not found) answers
//   without a pass; remove and execute top take a remove pass and add of a new
//   task an insert pass; add of a present task and edit take a remove pass
//   then an insert pass. The response shows in the cycle busy drops, so a new
//   request can be taken then.
//   Lookup of a task id is a parallel compare in every cell at the request.
//   Reset clears every cell's valid flag: the table is empty, no clearing pass.
// ----------------------------------------------------------------------------
module indexed_priority_task_table #(
  parameter int unsigned TABLE_SLOTS = ipt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 opcode_i,
  input  wire logic [ipt_pkg::ID_W-1:0]   user_id_i,
  input  wire logic [ipt_pkg::ID_W-1:0]   task_id_i,
  input  wire logic [ipt_pkg::PRIO_W-1:0] priority_req_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [ipt_pkg::ID_W-1:0]        top_user_o
);

  ipt_pkg::cell_cmd_t     cmd;
  ipt_pkg::lookup_t       look;
  ipt_pkg::entry_t        cell_entry [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] lt_vec;
  logic [TABLE_SLOTS-1:0] hit_vec;
  logic [TABLE_SLOTS-1:0] valid_vec;
  ipt_pkg::slot_t         hit_slot;

  // sequencer
  ipt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .opcode_i       (opcode_i),
    .user_id_i      (user_id_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .look_i         (look),
    .busy           (busy),
    .cmd_o          (cmd),
    .done_o         (done_o),
    .status_o       (status_o),
    .top_user_o     (top_user_o)
  );

  // cell chain, head at index 0
  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    ipt_pkg::entry_t prev_entry;
    ipt_pkg::entry_t next_entry;
    logic            prev_lt;

    if (g == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_lt    = 1'b0;
    end else begin : g_mid
      assign prev_entry = cell_entry[g-1];
      assign prev_lt    = lt_vec[g-1];
    end

    if (g == TABLE_SLOTS - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_body
      assign next_entry = cell_entry[g+1];
    end

    ipt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .prev_i    (prev_entry),
      .prev_lt_i (prev_lt),
      .next_i    (next_entry),
      .entry_o   (cell_entry[g]),
      .lt_o      (lt_vec[g]),
      .hit_o     (hit_vec[g])
    );

    assign valid_vec[g] = cell_entry[g].valid;
  end

  // one-hot select of the matching cell
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      hit_slot = hit_slot | ({$bits(ipt_pkg::slot_t){hit_vec[i]}} & cell_entry[i].data);
    end
  end

  // lookup summary, chain stays packed toward the head
  always_comb begin
    look.hit      = |hit_vec;
    look.hit_slot = hit_slot;
    look.empty    = !valid_vec[0];
    look.full     = valid_vec[TABLE_SLOTS-1];
    look.head     = cell_entry[0].data;
  end

`ifndef NO_ASSERTIONS
  a_hit_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("task id present in more than one cell");

  a_chain_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + {{(TABLE_SLOTS-1){1'b0}}, 1'b1})) == '0)
    else $error("valid cells not packed toward the head");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response while a request is in flight");

  a_exec_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == ipt_pkg::OP_EXEC) && !valid_vec[0])
      |=> (done_o && (status_o == ipt_pkg::ST_EMPTY)))
    else $error("execute top on empty table not flagged");

  a_busy_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without a request");
`endif

endmodule
`default_nettype wire
